// ----- src/toggle_list_truth_lookup_defines.svh -----
// ----------------------------------------------------------------------------
// Toggle list truth lookup: assertion macros
// Shared concurrent assertion forms for the lookup controller and datapath.
// ----------------------------------------------------------------------------
`ifndef TOGGLE_LIST_TRUTH_LOOKUP_DEFINES_SVH
`define TOGGLE_LIST_TRUTH_LOOKUP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define TLTL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tltl: implication check failed");

// Next-cycle implication, disabled while reset is asserted
`define TLTL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tltl: next-cycle check failed");

`endif

// ----- src/tltl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Toggle list truth lookup package
// Transaction types, request codes, default sizes and the control and status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tltl_pkg;

	// Default sizes
	localparam int NUM_PROPS_DEF  = 64;
	localparam int MAX_POINTS_DEF = 256;

	// Request codes
	localparam logic [1:0] REQ_WRITE_POINT  = 2'd0;
	localparam logic [1:0] REQ_WRITE_HEADER = 2'd1;
	localparam logic [1:0] REQ_QUERY        = 2'd2;

	// Input transaction
	typedef struct packed {
		logic [1:0]  req_type;
		logic [5:0]  prop_index;
		logic [7:0]  slot;
		logic [30:0] point_value;
		logic [8:0]  point_count;
		logic        first_value;
	} req_t;

	// Result transaction
	typedef struct packed {
		logic truth;
		logic is_answer;
	} rsp_t;

	// Controller to datapath commands
	typedef struct packed {
		logic clear_en;
		logic accept;
		logic hdr_load;
		logic probe;
	} ctl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic clr_last;
		logic search_end;
	} dp_sts_t;

endpackage
`default_nettype wire

// ----- src/tltl_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "toggle_list_truth_lookup_defines.svh"
// ----------------------------------------------------------------------------
// Toggle list truth lookup datapath
// Header and change point memories, search bounds, compare and result regs.
// ----------------------------------------------------------------------------
module tltl_dp #(
	parameter int NUM_PROPS  = tltl_pkg::NUM_PROPS_DEF,
	parameter int MAX_POINTS = tltl_pkg::MAX_POINTS_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  tltl_pkg::req_t      req,
	input  tltl_pkg::ctl_cmd_t  cmd,
	output tltl_pkg::dp_sts_t   sts,
	output tltl_pkg::rsp_t      rsp
);

	localparam int PW    = (NUM_PROPS > 1) ? $clog2(NUM_PROPS) : 1;
	localparam int IW    = $clog2(MAX_POINTS);
	localparam int LW    = $clog2(MAX_POINTS + 1);
	localparam int AW    = $clog2(NUM_PROPS * MAX_POINTS);
	localparam int HDR_W = LW + 1;

	// Memories
	logic [30:0]      cp_mem [NUM_PROPS * MAX_POINTS];
	logic [HDR_W-1:0] hdr_mem [NUM_PROPS];

	logic [30:0]      cp_rdata_q;
	logic [HDR_W-1:0] hdr_rdata_q;

	// Transaction and search registers
	logic [PW-1:0] clr_q;
	logic [30:0]   value_q;
	logic [AW-1:0] base_q;
	logic          oor_q;
	logic          first_q;
	logic [LW-1:0] low_q;
	logic [LW-1:0] hp1_q;
	logic [IW-1:0] mid_q;
	logic          truth_q;
	logic          ans_q;

	// Request decode
	logic          prop_ok;
	logic          slot_ok;
	logic [PW-1:0] prop_idx;
	logic [AW-1:0] req_base;
	logic [LW-1:0] sat_count;

	logic             cp_we;
	logic [AW-1:0]    cp_waddr;
	logic             hdr_we;
	logic [PW-1:0]    hdr_waddr;
	logic [HDR_W-1:0] hdr_wdata;
	logic [PW-1:0]    hdr_raddr;

	// Header stage
	logic [LW-1:0] hdr_len;
	logic          hdr_first;
	logic          hdr_end;
	logic [IW-1:0] mid0;

	// Probe stage
	logic          gt;
	logic          lt;
	logic          eq;
	logic [LW:0]   l_x;
	logic [LW:0]   m_x;
	logic [LW:0]   h_x;
	logic [LW:0]   mid_gt;
	logic [LW:0]   mid_lt;
	logic          cont;
	logic [LW:0]   nlow;
	logic [LW:0]   nhp1;
	logic [IW-1:0] mid_nx;
	logic          probe_end;
	logic          probe_truth;

	logic          cp_re;
	logic [IW-1:0] rd_mid;
	logic [AW-1:0] cp_raddr;

	// Decode the incoming request
	always_comb begin
		prop_ok   = (32'(req.prop_index) < NUM_PROPS);
		slot_ok   = (32'(req.slot) < MAX_POINTS);
		prop_idx  = PW'(req.prop_index);
		req_base  = AW'(req.prop_index) * AW'(MAX_POINTS);
		sat_count = (32'(req.point_count) > MAX_POINTS) ? LW'(MAX_POINTS) :
			LW'(req.point_count);
	end

	// Write ports: change points, headers and the post-reset header clear
	always_comb begin
		cp_we     = cmd.accept && (req.req_type == tltl_pkg::REQ_WRITE_POINT) &&
			prop_ok && slot_ok;
		cp_waddr  = req_base + AW'(req.slot);
		hdr_we    = cmd.clear_en ||
			(cmd.accept && (req.req_type == tltl_pkg::REQ_WRITE_HEADER) && prop_ok);
		hdr_waddr = cmd.clear_en ? clr_q : prop_idx;
		hdr_wdata = cmd.clear_en ? '0 : {sat_count, req.first_value};
		hdr_raddr = prop_ok ? prop_idx : '0;
	end

	// Header stage decode
	always_comb begin
		hdr_len   = hdr_rdata_q[HDR_W-1:1];
		hdr_first = hdr_rdata_q[0];
		hdr_end   = oor_q || (hdr_len == '0);
		mid0      = IW'((hdr_len - LW'(1)) >> 1);
	end

	// Probe stage: compare, then pick between both precomputed next midpoints
	always_comb begin
		gt     = (cp_rdata_q > value_q);
		lt     = (cp_rdata_q < value_q);
		eq     = !gt && !lt;
		l_x    = (LW+1)'(low_q);
		m_x    = (LW+1)'(mid_q);
		h_x    = (LW+1)'(hp1_q);
		mid_gt = (l_x + m_x - (LW+1)'(1)) >> 1;
		mid_lt = (m_x + h_x) >> 1;
		nlow   = lt ? (m_x + (LW+1)'(1)) : l_x;
		nhp1   = gt ? m_x : h_x;
		if (eq) begin
			cont = 1'b0;
		end else if (gt) begin
			cont = (l_x < m_x);
		end else begin
			cont = ((m_x + (LW+1)'(1)) < h_x);
		end
		mid_nx    = gt ? IW'(mid_gt) : IW'(mid_lt);
		probe_end = !cont;
		if (eq) begin
			probe_truth = mid_q[0] ^ first_q;
		end else if (nlow == '0) begin
			probe_truth = 1'b1;
		end else begin
			probe_truth = ~nlow[0] ^ first_q;
		end
	end

	// Read port of the change point memory
	always_comb begin
		cp_re    = (cmd.hdr_load && !hdr_end) || (cmd.probe && cont);
		rd_mid   = cmd.hdr_load ? mid0 : mid_nx;
		cp_raddr = base_q + AW'(rd_mid);
	end

	// Status to controller
	always_comb begin
		sts.clr_last   = (clr_q == PW'(NUM_PROPS - 1));
		sts.search_end = cmd.hdr_load ? hdr_end : probe_end;
	end

	// Change point memory
	always_ff @(posedge clk) begin
		if (cp_we) begin
			cp_mem[cp_waddr] <= req.point_value;
		end
		if (cp_re) begin
			cp_rdata_q <= cp_mem[cp_raddr];
		end
	end

	// Header memory
	always_ff @(posedge clk) begin
		if (hdr_we) begin
			hdr_mem[hdr_waddr] <= hdr_wdata;
		end
		if (cmd.accept) begin
			hdr_rdata_q <= hdr_mem[hdr_raddr];
		end
	end

	// Advance the header clear pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_en && !sts.clr_last) begin
			clr_q <= clr_q + PW'(1);
		end
	end

	// Capture the transaction, then narrow the bounds on each probe
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			value_q <= req.point_value;
			base_q  <= req_base;
			oor_q   <= !prop_ok;
			truth_q <= 1'b0;
			ans_q   <= (req.req_type == tltl_pkg::REQ_QUERY);
		end else if (cmd.hdr_load) begin
			low_q   <= '0;
			hp1_q   <= hdr_len;
			first_q <= hdr_first;
			mid_q   <= mid0;
			if (hdr_end) begin
				truth_q <= 1'b1;
			end
		end else if (cmd.probe) begin
			low_q <= LW'(nlow);
			hp1_q <= LW'(nhp1);
			mid_q <= mid_nx;
			if (probe_end) begin
				truth_q <= probe_truth;
			end
		end
	end

	assign rsp.truth     = truth_q;
	assign rsp.is_answer = ans_q;

	// Probed index always lies inside the live search window
	`TLTL_ASSERT_IMP(a_probe_window, clk, arst_n, cmd.probe, (LW'(mid_q) >= low_q) && (LW'(mid_q) < hp1_q))
	// Stored list lengths never exceed the list capacity
	`TLTL_ASSERT_IMP(a_hdr_len_bound, clk, arst_n, cmd.hdr_load, hdr_len <= LW'(MAX_POINTS))

endmodule
`default_nettype wire

// ----- src/tltl_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "toggle_list_truth_lookup_defines.svh"
// ----------------------------------------------------------------------------
// Toggle list truth lookup controller
// Sequences header clear, transaction accept, header read, probes and result.
// ----------------------------------------------------------------------------
module tltl_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  wire [1:0]           req_type,
	input  tltl_pkg::dp_sts_t   sts,
	output tltl_pkg::ctl_cmd_t  cmd,
	output logic                busy,
	output logic                done
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HDR,
		ST_PROBE,
		ST_RESP
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;

	// Decode commands from the current state
	always_comb begin
		cmd.clear_en = (state_q == ST_CLEAR);
		cmd.accept   = start && !busy_q;
		cmd.hdr_load = (state_q == ST_HDR);
		cmd.probe    = (state_q == ST_PROBE);
	end

	// Hold state, busy and the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			busy_q  <= 1'b1;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (sts.clr_last) begin
						state_q <= ST_IDLE;
						busy_q  <= 1'b0;
					end
				end
				ST_IDLE: begin
					if (start) begin
						busy_q <= 1'b1;
						if (req_type == tltl_pkg::REQ_QUERY) begin
							state_q <= ST_HDR;
						end else begin
							state_q <= ST_RESP;
							done_q  <= 1'b1;
						end
					end
				end
				ST_HDR: begin
					if (sts.search_end) begin
						state_q <= ST_RESP;
						done_q  <= 1'b1;
					end else begin
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (sts.search_end) begin
						state_q <= ST_RESP;
						done_q  <= 1'b1;
					end
				end
				ST_RESP: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b0;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;

	// An accepted transaction makes the block busy on the next cycle
	`TLTL_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy_q, busy_q)
	// One strobe per transaction
	`TLTL_ASSERT_NXT(a_done_single, clk, arst_n, done_q, !done_q)
	// A result only appears while the block still counts as busy
	`TLTL_ASSERT_IMP(a_done_busy, clk, arst_n, done_q, busy_q && (state_q == ST_RESP))

endmodule
`default_nettype wire

// ----- src/toggle_list_truth_lookup.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Toggle list truth lookup
// Per-proposition toggle lists with a binary-search truth query.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction (req) is taken on a rising edge with start high and busy
//   low. req_type selects a change point write, a header write (length and
//   start bit) or a truth query. Every transaction gives one result on rsp,
//   marked by done for exactly one cycle; the receiver cannot stall it.
//   Writes: done comes in the cycle after accept, busy is high only in that
//   cycle, and a new transaction can be taken once busy falls.
//   Queries: a header read, then one change point memory probe per
//   cycle; a list of length L takes up to ceil(log2(L+1)) probes (9 at 256
//   entries). The next transaction is taken only once the query is done;
//   the probe loop over the single change point read port sets the rate.
//   busy stays high until the cycle after done.
//   Reset: all headers clear to zero length; a clearing pass over all
//   NUM_PROPS headers runs after reset with busy high. Change point entries
//   hold nothing until written.
// ----------------------------------------------------------------------------
module toggle_list_truth_lookup #(
	parameter int NUM_PROPS  = tltl_pkg::NUM_PROPS_DEF,
	parameter int MAX_POINTS = tltl_pkg::MAX_POINTS_DEF
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             start,
	output logic            busy,
	input  tltl_pkg::req_t  req,
	output logic            done,
	output tltl_pkg::rsp_t  rsp
);

	tltl_pkg::ctl_cmd_t cmd;
	tltl_pkg::dp_sts_t  sts;

	// Sequence the search
	tltl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req.req_type),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy),
		.done     (done)
	);

	// Store lists and evaluate probes
	tltl_dp #(
		.NUM_PROPS  (NUM_PROPS),
		.MAX_POINTS (MAX_POINTS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Toggle list truth lookup testbench
// Drives write, header, query and unused transactions through the start/busy
// handshake, keeps its own copy of every toggle list, predicts each answer
// by the same fixed binary search and checks every done strobe against the
// oldest pending prediction. Queries never probe an entry that was not
// written; a list header is shortened first where one would.
// ----------------------------------------------------------------------------
module tb_top;
	import tltl_pkg::*;

	localparam int          NPROP      = NUM_PROPS_DEF;
	localparam int          NPOINT     = MAX_POINTS_DEF;
	localparam logic [1:0]  REQ_UNUSED = 2'd3;
	localparam logic [30:0] VAL_MAX    = 31'h7FFF_FFFF;
	localparam int          LIMIT      = 400000;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	req_t req;
	rsp_t rsp;

	// Shadow copy of the lists held by the block
	bit [30:0] cp_mem     [NPROP][NPOINT];
	bit        cp_written [NPROP][NPOINT];
	int        list_len   [NPROP];
	bit        start_bit  [NPROP];

	rsp_t        answer_q[$];
	int          mismatches = 0;
	int          items_sent = 0;
	int          calm_left  = 0;
	int unsigned cycle_count = 0;

	toggle_list_truth_lookup dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("%0t timeout with %0d results pending", $time, answer_q.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// Search the shadow list; flag any probe of an entry never written
	function automatic logic toggle_truth(input int prop, input logic [30:0] idx,
			output bit safe);
		int lo;
		int hi;
		int mid;
		int pos;
		bit found;
		safe  = 1'b1;
		lo    = 0;
		hi    = list_len[prop] - 1;
		pos   = -1;
		found = 1'b0;
		while (lo <= hi && !found) begin
			mid = (lo + hi) / 2;
			if (!cp_written[prop][mid])
				safe = 1'b0;
			if (cp_mem[prop][mid] > idx)
				hi = mid - 1;
			else if (cp_mem[prop][mid] < idx)
				lo = mid + 1;
			else begin
				pos   = mid;
				found = 1'b1;
			end
		end
		if (!found)
			pos = lo - 1;
		if (pos < 0)
			return 1'b1;
		return (pos[0] == start_bit[prop]) ? 1'b0 : 1'b1;
	endfunction

	// Apply an accepted transaction to the shadow lists and queue its answer
	function automatic void update_lists_and_predict(input req_t r);
		rsp_t exp_rsp;
		bit   safe;
		exp_rsp = '0;
		case (r.req_type)
			REQ_WRITE_POINT: begin
				cp_mem[r.prop_index][r.slot]     = r.point_value;
				cp_written[r.prop_index][r.slot] = 1'b1;
			end
			REQ_WRITE_HEADER: begin
				list_len[r.prop_index]  = (r.point_count > NPOINT) ? NPOINT : r.point_count;
				start_bit[r.prop_index] = r.first_value;
			end
			REQ_QUERY: begin
				exp_rsp.truth     = toggle_truth(r.prop_index, r.point_value, safe);
				exp_rsp.is_answer = 1'b1;
			end
			default: ;
		endcase
		answer_q.insert(answer_q.size(), exp_rsp);
	endfunction

	// Mostly short gaps, a few long ones, and runs with none
	function automatic int pick_gap();
		int r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm_left = $urandom_range(20, 60);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(13, 40);
	endfunction

	// Send one transaction and wait for it to be taken
	task automatic send_req(input req_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy !== 1'b0);
		update_lists_and_predict(r);
		if (r.req_type != REQ_UNUSED)
			items_sent++;
	endtask

	task automatic send_point(input int prop, input int slot, input logic [30:0] value);
		req_t r;
		r = req_t'({$urandom, $urandom});
		r.req_type    = REQ_WRITE_POINT;
		r.prop_index  = 6'(prop);
		r.slot        = 8'(slot);
		r.point_value = value;
		send_req(r);
	endtask

	task automatic send_header(input int prop, input logic [8:0] count, input bit first);
		req_t r;
		r = req_t'({$urandom, $urandom});
		r.req_type    = REQ_WRITE_HEADER;
		r.prop_index  = 6'(prop);
		r.point_count = count;
		r.first_value = first;
		send_req(r);
	endtask

	// Shorten the header to its written prefix where the search would leave it
	task automatic send_query(input int prop, input logic [30:0] value);
		req_t r;
		bit   safe;
		int   prefix;
		void'(toggle_truth(prop, value, safe));
		if (!safe) begin
			prefix = 0;
			while (prefix < NPOINT && cp_written[prop][prefix])
				prefix++;
			send_header(prop, 9'(prefix), start_bit[prop]);
		end
		r = req_t'({$urandom, $urandom});
		r.req_type    = REQ_QUERY;
		r.prop_index  = 6'(prop);
		r.point_value = value;
		send_req(r);
	endtask

	task automatic send_unused(input req_t r);
		r.req_type = REQ_UNUSED;
		send_req(r);
	endtask

	// Hold off the sender until every pending answer is back
	task automatic hold_until_drained();
		start <= 1'b0;
		do @(posedge clk); while (answer_q.size() != 0);
	endtask

	// Write a strictly increasing list and its header, in random order
	task automatic build_toggle_list(input int prop, input int n, input logic [8:0] count,
			input bit first, input int mode);
		longint pts[NPOINT];
		longint stepmax;
		bit     hdr_first;
		bit     descend;
		if (mode == 2) begin
			pts[n-1] = VAL_MAX;
			for (int i = n - 2; i >= 0; i--)
				pts[i] = pts[i+1] - $urandom_range(1, 1000);
		end else begin
			stepmax = (mode == 1) ? (64'd1 << 22) : 64'd4;
			pts[0] = (mode == 1) ? $urandom_range(0, VAL_MAX - n * stepmax) : $urandom_range(0, 20);
			for (int i = 1; i < n; i++)
				pts[i] = pts[i-1] + $urandom_range(1, stepmax);
		end
		hdr_first = $urandom_range(0, 1);
		descend   = ($urandom_range(0, 3) == 0);
		if (hdr_first)
			send_header(prop, count, first);
		for (int i = 0; i < n; i++)
			send_point(prop, descend ? n - 1 - i : i, 31'(pts[descend ? n - 1 - i : i]));
		if (!hdr_first)
			send_header(prop, count, first);
	endtask

	// Query around the entries of a list: on, just below, just above, far off
	task automatic query_list(input int prop, input int n, input int nq);
		longint v;
		int     k;
		for (int q = 0; q < nq; q++) begin
			k = (n > 0) ? $urandom_range(0, n - 1) : 0;
			case ((n > 0) ? $urandom_range(0, 5) : 5)
				0: v = cp_mem[prop][k];
				1: v = longint'(cp_mem[prop][k]) - 1;
				2: v = longint'(cp_mem[prop][k]) + 1;
				3: v = 0;
				4: v = VAL_MAX;
				default: v = $urandom_range(0, VAL_MAX);
			endcase
			if (v < 0)
				v = 0;
			if (v > VAL_MAX)
				v = VAL_MAX;
			send_query(prop, 31'(v));
		end
	endtask

	// Empty lists and the unused request code
	task automatic test_empty_and_unknown();
		send_query(0, 31'd0);
		send_query(NPROP - 1, VAL_MAX);
		send_unused('1);
		send_unused('0);
	endtask

	// Two-entry list reaching the top of the value range, both start bits
	task automatic test_short_list_edges();
		send_point(NPROP - 1, 0, 31'd5);
		send_point(NPROP - 1, 1, VAL_MAX);
		send_point(NPROP - 1, NPOINT - 1, VAL_MAX);
		send_header(NPROP - 1, 9'd2, 1'b1);
		send_query(NPROP - 1, 31'd0);
		send_query(NPROP - 1, 31'd5);
		send_query(NPROP - 1, 31'd6);
		send_query(NPROP - 1, VAL_MAX);
		send_header(NPROP - 1, 9'd2, 1'b0);
		send_query(NPROP - 1, 31'd6);
		send_query(NPROP - 1, VAL_MAX);
	endtask

	// An oversized header count, then an empty list with start bit set
	task automatic test_oversized_header();
		send_header(2, 9'd300, 1'b0);
		send_header(2, 9'd0, 1'b1);
		send_query(2, 31'd7);
	endtask

	// A list that is not increasing still answers by the fixed probe order
	task automatic test_unsorted_list();
		send_point(1, 0, 31'd50);
		send_point(1, 1, 31'd10);
		send_point(1, 2, 31'd30);
		send_header(1, 9'd3, 1'b0);
		send_query(1, 31'd10);
		send_query(1, 31'd30);
		send_query(1, 31'd40);
		send_query(1, 31'd50);
	endtask

	// Every slot of one list, header count saturated from the largest value
	task automatic test_full_list();
		int prop;
		prop = $urandom_range(3, NPROP - 2);
		build_toggle_list(prop, NPOINT, 9'd511, 1'($urandom_range(0, 1)),
			$urandom_range(0, 2));
		send_query(prop, 31'd0);
		send_query(prop, VAL_MAX);
		query_list(prop, NPOINT, 16);
	endtask

	// Mostly well-formed lists with queries, mixed with stray writes, unused requests and single queries
	task automatic test_random_lists(input int target);
		int   pick;
		int   prop;
		int   n;
		logic [8:0] count;
		while (items_sent < target) begin
			pick = $urandom_range(0, 99);
			prop = $urandom_range(0, NPROP - 1);
			if (pick < 70) begin
				pick = $urandom_range(0, 99);
				if (pick < 5)
					n = 0;
				else if (pick < 40)
					n = $urandom_range(1, 4);
				else if (pick < 90)
					n = $urandom_range(5, 32);
				else if (pick < 99)
					n = $urandom_range(33, 255);
				else
					n = NPOINT;
				count = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(n, 511)) : 9'(n);
				if (n > 0)
					build_toggle_list(prop, n, count, 1'($urandom_range(0, 1)),
						$urandom_range(0, 2));
				else
					send_header(prop, count, 1'($urandom_range(0, 1)));
				query_list(prop, n, $urandom_range(2, 8));
			end else if (pick < 80)
				send_point(prop, $urandom_range(0, NPOINT - 1), 31'($urandom_range(0, VAL_MAX)));
			else if (pick < 87)
				send_header(prop, 9'($urandom_range(0, 511)), 1'($urandom_range(0, 1)));
			else if (pick < 92)
				send_unused(req_t'({$urandom, $urandom}));
			else
				query_list(prop, list_len[prop], 1);
			if ($urandom_range(0, 149) == 0)
				hold_until_drained();
		end
	endtask

	// Check each result against the oldest prediction
	always @(posedge clk) begin
		rsp_t exp_rsp;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (answer_q.size() == 0) begin
				$display("%0t unexpected result truth=%b is_answer=%b",
					$time, rsp.truth, rsp.is_answer);
				mismatches++;
			end else begin
				exp_rsp = answer_q.pop_front();
				if (rsp.truth !== exp_rsp.truth) begin
					$display("%0t truth mismatch: expected %b actual %b",
						$time, exp_rsp.truth, rsp.truth);
					mismatches++;
				end
				if (rsp.is_answer !== exp_rsp.is_answer) begin
					$display("%0t is_answer mismatch: expected %b actual %b",
						$time, exp_rsp.is_answer, rsp.is_answer);
					mismatches++;
				end
			end
		end
	end

	initial begin
		start  = 1'b0;
		req    = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_and_unknown();
		test_short_list_edges();
		test_oversized_header();
		test_unsorted_list();
		test_full_list();
		hold_until_drained();
		test_random_lists(1900);

		// Drain, then allow the longest query latency
		start <= 1'b0;
		while (answer_q.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+src
src/tltl_pkg.sv
src/tltl_dp.sv
src/tltl_ctrl.sv
src/toggle_list_truth_lookup.sv
bench/tb_top.sv
